>>> design/bpc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
`default_nettype none
package bpc_pkg;

    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int DT_W    = 25;
    localparam int PROD_W  = 42;
    localparam int TEMP_W  = 19;
    localparam int OFF_W   = 36;
    localparam int SENS_W  = 35;
    localparam int SLO_W   = 18;
    localparam int PP_W    = 42;
    localparam int MUL_W   = 60;
    localparam int PRESS_W = 18;
    localparam int IDX_W   = 3;
    localparam int DIFF_W  = MUL_W - 21 + 1;
    localparam int P_W     = DIFF_W - 15;

    localparam logic signed [P_W-1:0] P_MAX = P_W'(131071);
    localparam logic signed [P_W-1:0] P_MIN = -P_W'(131072);

    localparam logic [IDX_W-1:0] REG_SENS          = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFFSET        = 3'd1;
    localparam logic [IDX_W-1:0] REG_SENS_TEMPCO   = 3'd2;
    localparam logic [IDX_W-1:0] REG_OFFSET_TEMPCO = 3'd3;
    localparam logic [IDX_W-1:0] REG_REF_TEMP      = 3'd4;
    localparam logic [IDX_W-1:0] REG_TEMP_COEFF    = 3'd5;

    localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

    typedef struct packed {
        logic [CAL_W-1:0] sens;
        logic [CAL_W-1:0] offset;
        logic [CAL_W-1:0] sens_tempco;
        logic [CAL_W-1:0] offset_tempco;
        logic [CAL_W-1:0] ref_temp;
        logic [CAL_W-1:0] temp_coeff;
    } cal_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic [RAW_W-1:0]         d1;
    } coef_t;

endpackage
`default_nettype wire

>>> design/bpc_coef.sv
// Front pipeline: dT, temperature, offset and sensitivity (three stages).
`default_nettype none
module bpc_coef (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bpc_pkg::cal_t              cal,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [bpc_pkg::RAW_W-1:0]  raw_temp,
    input  logic [bpc_pkg::RAW_W-1:0]  raw_press,
    output logic                       out_valid,
    input  logic                       out_ready,
    output bpc_pkg::coef_t             coef
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic adv1, adv2, adv3;

    logic signed [bpc_pkg::DT_W-1:0]   dt_next, dt_reg;
    logic [bpc_pkg::RAW_W-1:0]         d1_s1_reg, d1_s2_reg;
    logic signed [bpc_pkg::PROD_W-1:0] tprod_next, oprod_next, sprod_next;
    logic signed [bpc_pkg::PROD_W-1:0] tprod_reg, oprod_reg, sprod_reg;
    bpc_pkg::coef_t                    coef_next, coef_reg;

    assign adv3     = !s3_valid_reg || out_ready;
    assign adv2     = !s2_valid_reg || adv3;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    assign dt_next = $signed({1'b0, raw_temp}) - $signed({1'b0, cal.ref_temp, 8'b0});

    assign tprod_next = dt_reg * $signed({1'b0, cal.temp_coeff});
    assign oprod_next = dt_reg * $signed({1'b0, cal.offset_tempco});
    assign sprod_next = dt_reg * $signed({1'b0, cal.sens_tempco});

    always_comb
    begin
        coef_next.temp = $signed(tprod_reg[bpc_pkg::PROD_W-1:23]) + bpc_pkg::TEMP_BASE;
        coef_next.off  = $signed(oprod_reg[bpc_pkg::PROD_W-1:6])
                       + $signed({3'b0, cal.offset, 17'b0});
        coef_next.sens = $signed(sprod_reg[bpc_pkg::PROD_W-1:7])
                       + $signed({3'b0, cal.sens, 16'b0});
        coef_next.d1   = d1_s2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= in_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
            if (adv3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            dt_reg    <= dt_next;
            d1_s1_reg <= raw_press;
        end
        if (adv2)
        begin
            tprod_reg <= tprod_next;
            oprod_reg <= oprod_next;
            sprod_reg <= sprod_next;
            d1_s2_reg <= d1_s1_reg;
        end
        if (adv3)
            coef_reg <= coef_next;
    end

    assign out_valid = s3_valid_reg;
    assign coef      = coef_reg;

endmodule
`default_nettype wire

>>> design/bpc_press.sv
// Back pipeline: D1 * SENS in partial products, offset removal, saturation.
`default_nettype none
module bpc_press (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bpc_pkg::coef_t                      coef,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bpc_pkg::TEMP_W-1:0]   temperature_centi,
    output logic signed [bpc_pkg::PRESS_W-1:0]  pressure_centi_mbar,
    output logic                                pressure_clipped
);

    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic adv4, adv5, adv6;

    logic [bpc_pkg::PP_W-1:0]           pp_lo_next, pp_lo_reg;
    logic signed [bpc_pkg::PP_W-1:0]    pp_hi_next, pp_hi_reg;
    logic signed [bpc_pkg::MUL_W-1:0]   prod_next, prod_reg;
    logic signed [bpc_pkg::TEMP_W-1:0]  temp_s4_reg, temp_s5_reg, temp_s6_reg;
    logic signed [bpc_pkg::OFF_W-1:0]   off_s4_reg, off_s5_reg;
    logic signed [bpc_pkg::DIFF_W-1:0]  diff;
    logic signed [bpc_pkg::P_W-1:0]     p_full;
    logic signed [bpc_pkg::PRESS_W-1:0] press_next, press_reg;
    logic                               clip_next, clip_reg;

    assign adv6     = !s6_valid_reg || out_ready;
    assign adv5     = !s5_valid_reg || adv6;
    assign adv4     = !s4_valid_reg || adv5;
    assign in_ready = adv4;

    assign pp_lo_next = bpc_pkg::PP_W'(coef.d1) * bpc_pkg::PP_W'(coef.sens[bpc_pkg::SLO_W-1:0]);
    assign pp_hi_next = $signed({1'b0, coef.d1})
                      * $signed(coef.sens[bpc_pkg::SENS_W-1:bpc_pkg::SLO_W]);

    assign prod_next = ($signed(bpc_pkg::MUL_W'(pp_hi_reg)) <<< bpc_pkg::SLO_W)
                     + $signed({{(bpc_pkg::MUL_W-bpc_pkg::PP_W){1'b0}}, pp_lo_reg});

    always_comb
    begin
        diff = $signed(bpc_pkg::DIFF_W'($signed(prod_reg[bpc_pkg::MUL_W-1:21])))
             - $signed(bpc_pkg::DIFF_W'(off_s5_reg));
        p_full = diff[bpc_pkg::DIFF_W-1:15];
        if (p_full > bpc_pkg::P_MAX)
        begin
            press_next = bpc_pkg::PRESS_W'(bpc_pkg::P_MAX);
            clip_next  = 1'b1;
        end
        else if (p_full < bpc_pkg::P_MIN)
        begin
            press_next = bpc_pkg::PRESS_W'(bpc_pkg::P_MIN);
            clip_next  = 1'b1;
        end
        else
        begin
            press_next = p_full[bpc_pkg::PRESS_W-1:0];
            clip_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv4)
                s4_valid_reg <= in_valid;
            if (adv5)
                s5_valid_reg <= s4_valid_reg;
            if (adv6)
                s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            pp_lo_reg   <= pp_lo_next;
            pp_hi_reg   <= pp_hi_next;
            temp_s4_reg <= coef.temp;
            off_s4_reg  <= coef.off;
        end
        if (adv5)
        begin
            prod_reg    <= prod_next;
            temp_s5_reg <= temp_s4_reg;
            off_s5_reg  <= off_s4_reg;
        end
        if (adv6)
        begin
            press_reg   <= press_next;
            clip_reg    <= clip_next;
            temp_s6_reg <= temp_s5_reg;
        end
    end

    assign out_valid           = s6_valid_reg;
    assign temperature_centi   = temp_s6_reg;
    assign pressure_centi_mbar = press_reg;
    assign pressure_clipped    = clip_reg;

endmodule
`default_nettype wire

>>> design/baro_pressure_temp_compensation_unit.sv
// Top level: first-order barometric pressure and temperature compensation.
// Throughput: one transaction per cycle while out_ready is high; a six-stage
// pipeline with per-stage valid bits, so bubbles close up while the output is
// stalled.
// Reset clears all stage valid bits and sets every calibration word to zero.
`default_nettype none
module baro_pressure_temp_compensation_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bpc_pkg::IDX_W-1:0]           cfg_index,
    input  logic [bpc_pkg::CAL_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bpc_pkg::RAW_W-1:0]           raw_temp,
    input  logic [bpc_pkg::RAW_W-1:0]           raw_press,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bpc_pkg::TEMP_W-1:0]   temperature_centi,
    output logic signed [bpc_pkg::PRESS_W-1:0]  pressure_centi_mbar,
    output logic                                pressure_clipped
);

    bpc_pkg::cal_t  cal_reg;
    bpc_pkg::coef_t coef;
    logic           mid_valid, mid_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cal_reg <= '0;
        else if (cfg_we)
        begin
            case (cfg_index)
                bpc_pkg::REG_SENS:          cal_reg.sens          <= cfg_data;
                bpc_pkg::REG_OFFSET:        cal_reg.offset        <= cfg_data;
                bpc_pkg::REG_SENS_TEMPCO:   cal_reg.sens_tempco   <= cfg_data;
                bpc_pkg::REG_OFFSET_TEMPCO: cal_reg.offset_tempco <= cfg_data;
                bpc_pkg::REG_REF_TEMP:      cal_reg.ref_temp      <= cfg_data;
                bpc_pkg::REG_TEMP_COEFF:    cal_reg.temp_coeff    <= cfg_data;
                default:                    ;
            endcase
        end
    end

    bpc_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .raw_temp  (raw_temp),
        .raw_press (raw_press),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .coef      (coef)
    );

    bpc_press u_press (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (mid_valid),
        .in_ready            (mid_ready),
        .coef                (coef),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .temperature_centi   (temperature_centi),
        .pressure_centi_mbar (pressure_centi_mbar),
        .pressure_clipped    (pressure_clipped)
    );

endmodule
`default_nettype wire
